/* hw/rtl/satd_pkg.sv */
// satd_pkg: widths, block-size codes, pipeline control struct and helpers
// shared by the 4x4 Hadamard SATD block cost datapath.
// No dependencies.
`default_nettype none

package satd_pkg;

	localparam int PIX_BITS   = 8;
	localparam int LANES      = 8;
	localparam int GROUP      = 4;
	localparam int GROUPS     = LANES / GROUP;
	localparam int VFREQ      = 4;
	localparam int D_W        = PIX_BITS + 1;   // residual
	localparam int H_W        = D_W + 2;        // after 4-point row transform
	localparam int ACC_W      = H_W + 2;        // after 4-point column transform
	localparam int ABS_W      = ACC_W - 1;      // |coef| <= 4080
	localparam int LSUM_W     = ABS_W + 2;      // four coefs of one lane
	localparam int TILE_W     = LSUM_W + 3;     // eight lanes
	localparam int COST_W     = 20;
	localparam int ROW_W      = 5;
	localparam int FIFO_DEPTH = 2;
	localparam int CNT_W      = 2;

	localparam logic [1:0] BSZ_4X4   = 2'd0;
	localparam logic [1:0] BSZ_8X8   = 2'd1;
	localparam logic [1:0] BSZ_16X16 = 2'd2;

	localparam logic [ROW_W-1:0] LAST_4X4   = 5'd3;
	localparam logic [ROW_W-1:0] LAST_8X8   = 5'd7;
	localparam logic [ROW_W-1:0] LAST_16X16 = 5'd31;

	typedef logic signed [D_W-1:0]   satd_d_t;
	typedef logic signed [H_W-1:0]   satd_h_t;
	typedef logic signed [ACC_W-1:0] satd_acc_t;

	typedef struct packed {
		logic       valid;
		logic       tile_start;  // row 0 of a tile row
		logic       tile_end;    // row 3 of a tile row
		logic       blk_end;     // last row of the block
		logic [1:0] row;         // row within the tile
	} satd_ctrl_t;

	// mode 3 decodes as 16x16
	function automatic logic [1:0] decode_mode(input logic [1:0] m);
		logic [1:0] b;
		case (m)
			BSZ_4X4: b = BSZ_4X4;
			BSZ_8X8: b = BSZ_8X8;
			default: b = BSZ_16X16;
		endcase
		return b;
	endfunction

	function automatic logic [ROW_W-1:0] last_row(input logic [1:0] b);
		logic [ROW_W-1:0] l;
		case (b)
			BSZ_4X4: l = LAST_4X4;
			BSZ_8X8: l = LAST_8X8;
			default: l = LAST_16X16;
		endcase
		return l;
	endfunction

	// sign of Hadamard row k at column r: true when negative
	function automatic logic coef_neg(input logic [1:0] k, input logic [1:0] r);
		logic n;
		case (k)
			2'd0:    n = 1'b0;
			2'd1:    n = r[0];
			2'd2:    n = r[1];
			default: n = r[0] ^ r[1];
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/satd_hrow.sv */
// satd_hrow: residual and 4-point horizontal Hadamard for one group of
// four lanes. Combinational. Depends on satd_pkg.
`default_nettype none

module satd_hrow (
	input  wire logic [satd_pkg::GROUP*satd_pkg::PIX_BITS-1:0] src,
	input  wire logic [satd_pkg::GROUP*satd_pkg::PIX_BITS-1:0] refp,
	input  wire logic                                          blank,
	output satd_pkg::satd_h_t                                  h [satd_pkg::GROUP]
);

	satd_pkg::satd_d_t d [satd_pkg::GROUP];
	satd_pkg::satd_h_t x [satd_pkg::GROUP];

	always_comb begin
		for (int j = 0; j < satd_pkg::GROUP; j++) begin
			if (blank) begin
				d[j] = '0;
			end else begin
				d[j] = satd_pkg::satd_d_t'({1'b0, src[j*satd_pkg::PIX_BITS +: satd_pkg::PIX_BITS]})
				     - satd_pkg::satd_d_t'({1'b0, refp[j*satd_pkg::PIX_BITS +: satd_pkg::PIX_BITS]});
			end
			x[j] = satd_pkg::satd_h_t'(d[j]);
		end
		h[0] = x[0] + x[1] + x[2] + x[3];
		h[1] = x[0] - x[1] + x[2] - x[3];
		h[2] = x[0] + x[1] - x[2] - x[3];
		h[3] = x[0] - x[1] - x[2] + x[3];
	end

endmodule

`default_nettype wire

/* hw/rtl/satd_lane.sv */
// satd_lane: one lane's four vertical-frequency accumulators and the sum of
// their magnitudes at tile end. Depends on satd_pkg.
`default_nettype none

module satd_lane (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire satd_pkg::satd_ctrl_t       ctrl_s1,
	input  wire satd_pkg::satd_h_t          h_s1,
	output logic [satd_pkg::LSUM_W-1:0]     lane_sum_s3
);

	satd_pkg::satd_acc_t acc_q [satd_pkg::VFREQ];
	satd_pkg::satd_acc_t acc_nxt [satd_pkg::VFREQ];
	logic [satd_pkg::LSUM_W-1:0] mag_sum;

	always_comb begin
		satd_pkg::satd_acc_t c;
		for (int k = 0; k < satd_pkg::VFREQ; k++) begin
			c = satd_pkg::coef_neg(2'(k), ctrl_s1.row) ? -satd_pkg::satd_acc_t'(h_s1)
			                                           :  satd_pkg::satd_acc_t'(h_s1);
			acc_nxt[k] = ctrl_s1.tile_start ? c : acc_q[k] + c;
		end
	end

	// magnitudes of the finished column sums; acc_q holds row 3 by now
	always_comb begin
		satd_pkg::satd_acc_t a;
		mag_sum = '0;
		for (int k = 0; k < satd_pkg::VFREQ; k++) begin
			a = acc_q[k][satd_pkg::ACC_W-1] ? -acc_q[k] : acc_q[k];
			mag_sum = mag_sum + satd_pkg::LSUM_W'(a[satd_pkg::ABS_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctrl_s1.valid) begin
				for (int k = 0; k < satd_pkg::VFREQ; k++) acc_q[k] <= acc_nxt[k];
			end
			lane_sum_s3 <= mag_sum;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/satd_merge.sv */
// satd_merge: adds the eight lane sums into a tile cost, keeps the block
// total and holds finished costs in a two-entry output queue.
// Depends on satd_pkg.
`default_nettype none

module satd_merge (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [satd_pkg::LSUM_W-1:0]  lane_sum_s3 [satd_pkg::LANES],
	input  wire satd_pkg::satd_ctrl_t         ctrl_s3,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [satd_pkg::COST_W-1:0]       out_cost,
	output logic                              en
);

	logic [satd_pkg::TILE_W-1:0] tile_sum;
	logic [satd_pkg::TILE_W-1:0] tile_s4;
	satd_pkg::satd_ctrl_t        ctrl_s4;
	logic [satd_pkg::COST_W-1:0] block_sum_q;
	logic [satd_pkg::COST_W-1:0] block_nxt;
	logic [satd_pkg::COST_W-1:0] ent_q [satd_pkg::FIFO_DEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [satd_pkg::CNT_W-1:0]  cnt_q;
	logic                        push;
	logic                        pop;

	always_comb begin
		tile_sum = '0;
		for (int i = 0; i < satd_pkg::LANES; i++) begin
			tile_sum = tile_sum + satd_pkg::TILE_W'(lane_sum_s3[i]);
		end
	end

	assign en        = cnt_q != satd_pkg::CNT_W'(satd_pkg::FIFO_DEPTH);
	assign block_nxt = block_sum_q + satd_pkg::COST_W'(tile_s4);
	assign push      = en && ctrl_s4.valid && ctrl_s4.blk_end;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_cost  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4     <= '0;
			block_sum_q <= '0;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (en) begin
				ctrl_s4 <= ctrl_s3;
				if (ctrl_s4.valid && ctrl_s4.tile_end) begin
					block_sum_q <= ctrl_s4.blk_end ? '0 : block_nxt;
				end
			end
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) tile_s4 <= tile_sum;
		if (push) ent_q[wr_ptr_q] <= block_nxt;
	end

endmodule

`default_nettype wire

/* hw/rtl/hadamard_satd_block_cost.sv */
// hadamard_satd_block_cost: top level of the 4x4 Hadamard SATD block cost.
// Depends on satd_pkg, satd_hrow, satd_lane, satd_merge.
//
//  channel | dir | fields (low bit up)                          | beat
//  --------+-----+----------------------------------------------+---------------
//  s_axis  | in  | tdata: src_pixels[63:0], ref_pixels[127:64]  | one pixel row
//          |     | tuser: mode[1:0]                             |
//  m_axis  | out | tdata: cost[19:0], zero[23:20]               | one block cost
//
// Cycles: one row beat per clock unless stalled; lanes and merge stage pipelined.
// Path: a block's cost is built through h_s1, acc_q, lane_sum_s3 and tile_s4, then queued.
// Stalls: a two-entry output queue absorbs results; s_axis_tready drops only
//   while two finished costs wait unread, and the whole pipe then holds.
// Reset: arst_n clears the row counter, block size, block sum, stage valids
//   and the output queue; the coefficient accumulators need no reset since
//   row 0 of every tile overwrites them.
`default_nettype none

module hadamard_satd_block_cost (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // src_pixels[63:0], ref_pixels[127:64]
	input  wire logic [1:0]   s_axis_tuser,   // mode[1:0]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [23:0]       m_axis_tdata    // cost[19:0], zero pad[23:20]
);

	localparam int GRP_BITS = satd_pkg::GROUP * satd_pkg::PIX_BITS;
	localparam int ROW_BITS = satd_pkg::LANES * satd_pkg::PIX_BITS;

	logic                          en;
	logic                          accept;
	logic [satd_pkg::ROW_W-1:0]    row_count_q;
	logic [1:0]                    block_size_q;
	logic [1:0]                    bsz;
	logic                          blk_end;
	satd_pkg::satd_ctrl_t          ctrl_in;
	satd_pkg::satd_ctrl_t          ctrl_s1;
	satd_pkg::satd_ctrl_t          ctrl_s2;
	satd_pkg::satd_ctrl_t          ctrl_s3;
	satd_pkg::satd_h_t             h_comb [satd_pkg::LANES];
	satd_pkg::satd_h_t             h_s1   [satd_pkg::LANES];
	logic [satd_pkg::LSUM_W-1:0]   lane_sum_s3 [satd_pkg::LANES];
	logic [satd_pkg::COST_W-1:0]   cost;

	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;

	// block size comes from the first row; later rows use the latched one
	assign bsz     = (row_count_q == '0) ? satd_pkg::decode_mode(s_axis_tuser) : block_size_q;
	assign blk_end = row_count_q >= satd_pkg::last_row(bsz);

	always_comb begin
		ctrl_in.valid      = 1'b1;
		ctrl_in.row        = row_count_q[1:0];
		ctrl_in.tile_start = row_count_q[1:0] == 2'd0;
		ctrl_in.tile_end   = row_count_q[1:0] == 2'd3;
		ctrl_in.blk_end    = blk_end;
	end

	// row transform, one unit per group of four lanes; 4x4 blanks the upper group
	for (genvar g = 0; g < satd_pkg::GROUPS; g++) begin : g_hrow
		satd_pkg::satd_h_t hg [satd_pkg::GROUP];

		satd_hrow u_hrow (
			.src   (s_axis_tdata[g*GRP_BITS +: GRP_BITS]),
			.refp  (s_axis_tdata[ROW_BITS + g*GRP_BITS +: GRP_BITS]),
			.blank ((g != 0) && (bsz == satd_pkg::BSZ_4X4)),
			.h     (hg)
		);

		for (genvar j = 0; j < satd_pkg::GROUP; j++) begin : g_map
			assign h_comb[g*satd_pkg::GROUP + j] = hg[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= '0;
			block_size_q <= satd_pkg::BSZ_4X4;
			ctrl_s1      <= '0;
			ctrl_s2      <= '0;
			ctrl_s3      <= '0;
		end else begin
			if (accept) begin
				block_size_q <= bsz;
				row_count_q  <= blk_end ? '0 : row_count_q + 1'b1;
			end
			if (en) begin
				ctrl_s1 <= accept ? ctrl_in : '0;
				ctrl_s2 <= ctrl_s1;
				ctrl_s3 <= ctrl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < satd_pkg::LANES; i++) h_s1[i] <= h_comb[i];
		end
	end

	// column transform lanes
	for (genvar i = 0; i < satd_pkg::LANES; i++) begin : g_lane
		satd_lane u_lane (
			.clk         (clk),
			.en          (en),
			.ctrl_s1     (ctrl_s1),
			.h_s1        (h_s1[i]),
			.lane_sum_s3 (lane_sum_s3[i])
		);
	end

	satd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.lane_sum_s3 (lane_sum_s3),
		.ctrl_s3     (ctrl_s3),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_cost    (cost),
		.en          (en)
	);

	assign m_axis_tdata = {4'b0, cost};

`ifndef SYNTHESIS
	// input is refused only while finished costs are waiting
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	// a block always ends on the last row of a tile
	a_blk_end_tile: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s1.valid && ctrl_s1.blk_end |-> ctrl_s1.tile_end)
		else $error("block ended inside a tile");

	// the row after a block's last row starts a new block
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && blk_end |=> row_count_q == '0)
		else $error("row counter did not wrap at block end");

	// latched block size is always a decoded code
	a_bsz_code: assert property (@(posedge clk) disable iff (!arst_n)
		block_size_q != 2'd3)
		else $error("undecoded block size latched");
`endif

endmodule

`default_nettype wire
